[design/sav_pkg.sv]
// sav_pkg: widths and pipeline sideband types for the axis velocity block.
// No dependencies. Every other design file refers to it by scoped names.
package sav_pkg;

  localparam int MOVE_W  = 32;  // signed move component, fixed point
  localparam int SPEED_W = 31;  // unsigned speed, same fraction as moves
  localparam int SQ_W    = 64;  // sum of three squares
  localparam int ROOT_W  = 32;  // floor(sqrt(sum))
  localparam int REM_W   = 34;  // square root partial remainder
  localparam int PROD_W  = 63;  // speed * |m_i|
  localparam int QUO_W   = 31;  // quotient, never above speed
  localparam int LANES   = 3;

  // Carried alongside the square root pipeline
  typedef struct packed {
    logic [LANES-1:0][PROD_W-1:0] prod;
    logic [LANES-1:0]             neg;
    logic [LANES-1:0]             nz;
  } sqrt_side_t;

  // Carried alongside the divider pipeline
  typedef struct packed {
    logic [LANES-1:0] neg;
    logic [LANES-1:0] nz;
  } div_side_t;

endpackage

[design/sav_if.sv]
// sav_in_if / sav_out_if: valid/ready channels for move requests and velocity results.
// Depends on sav_pkg for field widths.
interface sav_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [sav_pkg::MOVE_W-1:0]         move_x;
  logic signed [sav_pkg::MOVE_W-1:0]         move_y;
  logic signed [sav_pkg::MOVE_W-1:0]         move_z;
  logic        [sav_pkg::SPEED_W-1:0]        speed;
  modport source (output valid, move_x, move_y, move_z, speed, input ready);
  modport sink   (input valid, move_x, move_y, move_z, speed, output ready);
endinterface

interface sav_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [sav_pkg::MOVE_W-1:0] vel_x;
  logic signed [sav_pkg::MOVE_W-1:0] vel_y;
  logic signed [sav_pkg::MOVE_W-1:0] vel_z;
  modport source (output valid, vel_x, vel_y, vel_z, input ready);
  modport sink   (input valid, vel_x, vel_y, vel_z, output ready);
endinterface

[design/sav_sqrt_pipe.sv]
// sav_sqrt_pipe: 32-stage restoring integer square root, one root bit per stage.
// Depends on sav_pkg (widths, sqrt_side_t).
module sav_sqrt_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [sav_pkg::SQ_W-1:0]    in_sq,
  input  sav_pkg::sqrt_side_t         in_side,
  output logic                        out_valid,
  output logic [sav_pkg::ROOT_W-1:0]  out_root,
  output sav_pkg::sqrt_side_t         out_side
);

  localparam int N = sav_pkg::ROOT_W;

  logic                        valid_r [1:N];
  logic [sav_pkg::SQ_W-1:0]    sq_r    [1:N];
  logic [sav_pkg::REM_W-1:0]   rem_r   [1:N];
  logic [sav_pkg::ROOT_W-1:0]  root_r  [1:N];
  sav_pkg::sqrt_side_t         side_r  [1:N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                        cur_valid;
    logic [sav_pkg::SQ_W-1:0]    cur_sq;
    logic [sav_pkg::REM_W-1:0]   cur_rem;
    logic [sav_pkg::ROOT_W-1:0]  cur_root;
    sav_pkg::sqrt_side_t         cur_side;
    logic [sav_pkg::REM_W+1:0]   remx;
    logic [sav_pkg::REM_W+1:0]   trial;

    if (k == 0) begin : g_first
      assign cur_valid = in_valid;
      assign cur_sq    = in_sq;
      assign cur_rem   = '0;
      assign cur_root  = '0;
      assign cur_side  = in_side;
    end else begin : g_next
      assign cur_valid = valid_r[k];
      assign cur_sq    = sq_r[k];
      assign cur_rem   = rem_r[k];
      assign cur_root  = root_r[k];
      assign cur_side  = side_r[k];
    end

    // bring down the next two bits, try subtracting 4*root + 1
    assign remx  = {cur_rem, cur_sq[sav_pkg::SQ_W-1 -: 2]};
    assign trial = remx - {2'b00, cur_root, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k+1] <= 1'b0;
      end else if (en) begin
        valid_r[k+1] <= cur_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k+1]   <= {cur_sq[sav_pkg::SQ_W-3:0], 2'b00};
        side_r[k+1] <= cur_side;
        if (!trial[sav_pkg::REM_W+1]) begin
          rem_r[k+1]  <= trial[sav_pkg::REM_W-1:0];
          root_r[k+1] <= {cur_root[sav_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[k+1]  <= remx[sav_pkg::REM_W-1:0];
          root_r[k+1] <= {cur_root[sav_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = valid_r[N];
  assign out_root  = root_r[N];
  assign out_side  = side_r[N];

endmodule

[design/sav_div_pipe.sv]
// sav_div_pipe: three-lane restoring divider, 31 stages, one quotient bit per stage.
// Depends on sav_pkg (widths, div_side_t). Quotient must fit in QUO_W bits.
module sav_div_pipe (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             en,
  input  logic                                             in_valid,
  input  logic [sav_pkg::ROOT_W-1:0]                       in_den,
  input  logic [sav_pkg::LANES-1:0][sav_pkg::PROD_W-1:0]   in_num,
  input  sav_pkg::div_side_t                               in_side,
  output logic                                             out_valid,
  output logic [sav_pkg::LANES-1:0][sav_pkg::QUO_W-1:0]    out_quo,
  output sav_pkg::div_side_t                               out_side
);

  localparam int N  = sav_pkg::QUO_W;
  localparam int RW = sav_pkg::ROOT_W;

  logic                                           valid_r [1:N];
  logic [RW-1:0]                                  den_r   [1:N];
  logic [sav_pkg::LANES-1:0][N-1:0]               low_r   [1:N];
  logic [sav_pkg::LANES-1:0][RW-1:0]              rem_r   [1:N];
  logic [sav_pkg::LANES-1:0][N-1:0]               quo_r   [1:N];
  sav_pkg::div_side_t                             side_r  [1:N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                                 cur_valid;
    logic [RW-1:0]                        cur_den;
    logic [sav_pkg::LANES-1:0][N-1:0]     cur_low;
    logic [sav_pkg::LANES-1:0][RW-1:0]    cur_rem;
    logic [sav_pkg::LANES-1:0][N-1:0]     cur_quo;
    sav_pkg::div_side_t                   cur_side;
    logic [sav_pkg::LANES-1:0][RW-1:0]    rem_nxt;
    logic [sav_pkg::LANES-1:0][N-1:0]     quo_nxt;

    if (k == 0) begin : g_first
      // upper numerator bits start as the remainder; below den by the range
      for (genvar l = 0; l < sav_pkg::LANES; l++) begin : g_lane
        assign cur_rem[l] = in_num[l][sav_pkg::PROD_W-1 -: RW];
        assign cur_low[l] = in_num[l][N-1:0];
      end
      assign cur_valid = in_valid;
      assign cur_den   = in_den;
      assign cur_quo   = '0;
      assign cur_side  = in_side;
    end else begin : g_next
      assign cur_valid = valid_r[k];
      assign cur_den   = den_r[k];
      assign cur_low   = low_r[k];
      assign cur_rem   = rem_r[k];
      assign cur_quo   = quo_r[k];
      assign cur_side  = side_r[k];
    end

    always_comb begin
      logic [RW:0] remx;
      logic [RW:0] trial;
      for (int l = 0; l < sav_pkg::LANES; l++) begin
        remx  = {cur_rem[l], cur_low[l][N-1]};
        trial = remx - {1'b0, cur_den};
        if (!trial[RW]) begin
          rem_nxt[l] = trial[RW-1:0];
          quo_nxt[l] = {cur_quo[l][N-2:0], 1'b1};
        end else begin
          rem_nxt[l] = remx[RW-1:0];
          quo_nxt[l] = {cur_quo[l][N-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k+1] <= 1'b0;
      end else if (en) begin
        valid_r[k+1] <= cur_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k+1]  <= cur_den;
        side_r[k+1] <= cur_side;
        rem_r[k+1]  <= rem_nxt;
        quo_r[k+1]  <= quo_nxt;
        for (int l = 0; l < sav_pkg::LANES; l++) begin
          low_r[k+1][l] <= {cur_low[l][N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = valid_r[N];
  assign out_quo   = quo_r[N];
  assign out_side  = side_r[N];

endmodule

[design/speed_to_axis_velocity_3d_top.sv]
// speed_to_axis_velocity_3d_top: splits a path speed into X/Y/Z velocities along a move.
// Depends on sav_pkg, sav_if (channels), sav_sqrt_pipe and sav_div_pipe.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------
//  in_req   | in  | valid/ready        | move_x, move_y, move_z (s32), speed (u31)
//  out_res  | out | valid/ready        | vel_x, vel_y, vel_z (s32)
//
// Accepts one request per cycle while out_res is not stalled; the pipe has 3 front stages,
// 32 square root stages, 31 divider stages and 1 output register.
// Latency is set by the bit-serial root and divider pipelines.
// rst_n is synchronous, active low, and clears only the valid bits.
// A stall at out_res freezes the whole pipe; in_req.ready follows it
// combinationally, so no request is dropped or repeated.
module speed_to_axis_velocity_3d_top (
  input  logic         clk,
  input  logic         rst_n,
  sav_in_if.sink       in_req,
  sav_out_if.source    out_res
);

  localparam int L  = sav_pkg::LANES;
  localparam int MW = sav_pkg::MOVE_W;

  logic en;

  // Stage A: magnitudes and signs
  logic                     a_valid_r;
  logic [L-1:0][MW-1:0]     a_mag_r;
  logic [L-1:0]             a_neg_r;
  logic [sav_pkg::SPEED_W-1:0] a_speed_r;
  logic [L-1:0][MW-1:0]     mv;

  // Stage B: squares and speed products
  logic                                   b_valid_r;
  logic [L-1:0][2*MW-1:0]                 b_sq_r;
  sav_pkg::sqrt_side_t                    b_side_r;

  // Stage C: sum of squares
  logic                                   c_valid_r;
  logic [sav_pkg::SQ_W-1:0]               c_sum_r;
  sav_pkg::sqrt_side_t                    c_side_r;

  logic                                   s_valid;
  logic [sav_pkg::ROOT_W-1:0]             s_root;
  sav_pkg::sqrt_side_t                    s_side;
  sav_pkg::div_side_t                     s_dside;

  logic                                   d_valid;
  logic [L-1:0][sav_pkg::QUO_W-1:0]       d_quo;
  sav_pkg::div_side_t                     d_side;

  logic                   o_valid_r;
  logic [L-1:0][MW-1:0]   o_vel_r;
  logic [L-1:0][MW-1:0]   o_vel_nxt;

  // whole pipe moves unless the output holds an untaken result
  assign en           = !o_valid_r || out_res.ready;
  assign in_req.ready = en;

  assign mv[0] = in_req.move_x;
  assign mv[1] = in_req.move_y;
  assign mv[2] = in_req.move_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_req.valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      o_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage A: -2^31 maps to 2^31, still fits unsigned 32 bits
      for (int i = 0; i < L; i++) begin
        a_neg_r[i] <= mv[i][MW-1];
        a_mag_r[i] <= mv[i][MW-1] ? (~mv[i] + 1'b1) : mv[i];
      end
      a_speed_r <= in_req.speed;

      // stage B: one multiplier per square, one per product
      for (int i = 0; i < L; i++) begin
        b_sq_r[i]        <= a_mag_r[i] * a_mag_r[i];
        b_side_r.prod[i] <= a_speed_r * a_mag_r[i];
        b_side_r.nz[i]   <= (a_mag_r[i] != '0);
      end
      b_side_r.neg <= a_neg_r;

      // stage C: exact, sum is at most 3 * 2^62
      c_sum_r  <= b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
      c_side_r <= b_side_r;

      o_vel_r <= o_vel_nxt;
    end
  end

  sav_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_valid_r),
    .in_sq     (c_sum_r),
    .in_side   (c_side_r),
    .out_valid (s_valid),
    .out_root  (s_root),
    .out_side  (s_side)
  );

  assign s_dside.neg = s_side.neg;
  assign s_dside.nz  = s_side.nz;

  // zero root only when all axes are zero; nz then masks the quotient
  sav_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s_valid),
    .in_den    (s_root),
    .in_num    (s_side.prod),
    .in_side   (s_dside),
    .out_valid (d_valid),
    .out_quo   (d_quo),
    .out_side  (d_side)
  );

  always_comb begin
    logic [MW-1:0] q;
    for (int i = 0; i < L; i++) begin
      q = {1'b0, d_quo[i]};
      if (!d_side.nz[i]) begin
        o_vel_nxt[i] = '0;
      end else if (d_side.neg[i]) begin
        o_vel_nxt[i] = ~q + 1'b1;
      end else begin
        o_vel_nxt[i] = q;
      end
    end
  end

  assign out_res.valid = o_valid_r;
  assign out_res.vel_x = o_vel_r[0];
  assign out_res.vel_y = o_vel_r[1];
  assign out_res.vel_z = o_vel_r[2];

endmodule

[tb/tb_speed_to_axis_velocity_3d_top.sv]
// Testbench for speed_to_axis_velocity_3d_top: directed and random move requests,
// checked against an in-bench model of speed * |m_i| / floor(sqrt(|m|^2)).
// Depends on sav_pkg, sav_if and the design files.
module tb_speed_to_axis_velocity_3d_top;

  localparam int NUM_RANDOM = 1600;
  localparam int PIPE_LAT   = 67;

  typedef struct packed {
    logic signed [sav_pkg::MOVE_W-1:0]  move_x;
    logic signed [sav_pkg::MOVE_W-1:0]  move_y;
    logic signed [sav_pkg::MOVE_W-1:0]  move_z;
    logic        [sav_pkg::SPEED_W-1:0] speed;
  } move_req_t;

  typedef struct packed {
    logic signed [sav_pkg::MOVE_W-1:0] vel_x;
    logic signed [sav_pkg::MOVE_W-1:0] vel_y;
    logic signed [sav_pkg::MOVE_W-1:0] vel_z;
  } axis_vel_t;

  logic clk;
  logic rst_n;

  sav_in_if  in_req();
  sav_out_if out_res();

  speed_to_axis_velocity_3d_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req.sink),
    .out_res (out_res.source)
  );

  move_req_t pending_moves[$];
  axis_vel_t expected_vels[$];
  int        mismatches;
  int        send_idle_pct;
  int        recv_idle_pct;
  bit        in_fire;

  // floor(sqrt(n)), bit by bit
  function automatic logic [31:0] floor_root(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[31:0];
  endfunction

  function automatic axis_vel_t axis_velocity(move_req_t m);
    logic [2:0][31:0] comp;
    logic [2:0][31:0] mag;
    logic [2:0][31:0] vel;
    logic [63:0]      sum;
    logic [31:0]      len;
    logic [63:0]      q;
    axis_vel_t        r;
    comp = {m.move_x, m.move_y, m.move_z};
    sum  = 0;
    for (int i = 0; i < 3; i++) begin
      // -2^31 negates to 2^31, which still fits 32 bits unsigned
      mag[i] = comp[i][31] ? (~comp[i] + 32'd1) : comp[i];
      sum    = sum + 64'(mag[i]) * 64'(mag[i]);
    end
    len = floor_root(sum);
    for (int i = 0; i < 3; i++) begin
      q = 0;
      if (len != 0 && mag[i] != 0) q = (64'(m.speed) * 64'(mag[i])) / 64'(len);
      vel[i] = comp[i][31] ? (~q[31:0] + 32'd1) : q[31:0];
    end
    r.vel_x = vel[2];
    r.vel_y = vel[1];
    r.vel_z = vel[0];
    return r;
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'($signed($urandom_range(0, 2000)) - 1000);
      4: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic move_req_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                   logic [30:0] s);
    move_req_t m;
    m.move_x = x;
    m.move_y = y;
    m.move_z = z;
    m.speed  = s;
    return m;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Driver: new request presented on the falling edge once the last one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else if (!in_req.valid || in_fire) begin
      if (pending_moves.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_req.valid  <= 1'b1;
        in_req.move_x <= pending_moves[0].move_x;
        in_req.move_y <= pending_moves[0].move_y;
        in_req.move_z <= pending_moves[0].move_z;
        in_req.speed  <= pending_moves[0].speed;
      end else begin
        in_req.valid <= 1'b0;
      end
    end
    out_res.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: acceptance on both channels sampled at the rising edge
  always @(posedge clk) begin
    move_req_t acc;
    axis_vel_t exp_v;
    in_fire = rst_n && in_req.valid && in_req.ready;
    if (in_fire) begin
      acc = pending_moves.pop_front();
      expected_vels.push_back(axis_velocity(acc));
    end
    if (rst_n && out_res.valid && out_res.ready) begin
      if (expected_vels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %h %h %h",
                   out_res.vel_x, out_res.vel_y, out_res.vel_z);
      end else begin
        exp_v = expected_vels.pop_front();
        if (exp_v.vel_x !== out_res.vel_x || exp_v.vel_y !== out_res.vel_y ||
            exp_v.vel_z !== out_res.vel_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h %h, got %h %h %h",
                     exp_v.vel_x, exp_v.vel_y, exp_v.vel_z,
                     out_res.vel_x, out_res.vel_y, out_res.vel_z);
        end
      end
    end
  end

  // Stimulus: directed corners, then three phases of random requests, the last with no idling
  initial begin
    mismatches     = 0;
    in_fire        = 1'b0;
    send_idle_pct  = 23;
    recv_idle_pct  = 47;
    rst_n          = 1'b0;
    in_req.valid   = 1'b0;
    in_req.move_x  = '0;
    in_req.move_y  = '0;
    in_req.move_z  = '0;
    in_req.speed   = '0;
    out_res.ready  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero move, single axes (exact +-speed), most negative, all-max
    pending_moves.push_back(mk(0, 0, 0, 31'h7fff_ffff));
    pending_moves.push_back(mk(32'h0001_0000, 0, 0, 31'h7fff_ffff));
    pending_moves.push_back(mk(0, 32'hffff_0000, 0, 31'h0001_0000));
    pending_moves.push_back(mk(0, 0, 32'h8000_0000, 31'h7fff_ffff));
    pending_moves.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               31'h7fff_ffff));
    pending_moves.push_back(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                               31'h7fff_ffff));
    pending_moves.push_back(mk(32'h7fff_ffff, 32'h8000_0000, 0, 31'h5555_5555));
    pending_moves.push_back(mk(1, 1, 1, 31'h7fff_ffff));
    pending_moves.push_back(mk(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0));
    pending_moves.push_back(mk(3, 4, 0, 31'd5));
    pending_moves.push_back(mk(32'hfffd_0000, 32'h0004_0000, 32'h000c_0000,
                               31'h000d_0000));
    pending_moves.push_back(mk(32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 1));
    pending_moves.push_back(mk(1, 0, 32'h7fff_ffff, 31'h2aaa_aaaa));

    for (int ph = 0; ph < 3; ph++) begin
      for (int i = 0; i < NUM_RANDOM / 3; i++)
        pending_moves.push_back(mk(rand_comp(), rand_comp(), rand_comp(),
          $urandom_range(0, 3) == 0 ? 31'h7fff_ffff : 31'($urandom())));
      wait (pending_moves.size() == 0);
      @(negedge clk);
      if (ph == 0) begin
        send_idle_pct = 47;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end

    wait (expected_vels.size() == 0);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (mismatches == 0 && expected_vels.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
